[design/fpr_pkg.sv]
// Shared types, widths, register codes and saturation helper for the film pixel resolve block.
// Used by fpr_lane, fpr_merge and film_pixel_resolve; depends on nothing else.
package fpr_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int DW          = 32;                // pixel data width
  localparam int SCW         = 24;                // scale register width
  localparam int NUM_W       = DW + FRAC_BITS;    // magnitude of sum * 2^F
  localparam int QW          = DW;                // quotient bits, top bit flags overflow
  localparam int CMP_W       = DW + QW - 1;       // widest shifted divisor
  localparam int PROD_W      = DW + SCW + 1;      // signed data times unsigned scale
  localparam int SUM_W       = PROD_W + 1;
  localparam int LANE_STAGES = QW + 4;            // entry, divide steps, three arithmetic stages
  localparam int N_LANES     = 3;
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] REG_SPLAT_SCALE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_SCALE = CFG_IDX_W'(1);

  localparam logic [SCW-1:0] SCALE_ONE = SCW'(1) << FRAC_BITS;

  typedef logic signed [DW-1:0]     pix_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic [SCW-1:0]           scale_t;

  typedef struct packed {
    logic adv;    // pipeline advances this cycle
    logic vld;    // last lane stage holds a request
    logic last;   // last pixel flag of that request
  } fpr_ctl_t;

  localparam logic signed [SUM_W-1:0] SAT_HI = {{(SUM_W-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_LO = {{(SUM_W-DW+1){1'b1}}, {(DW-1){1'b0}}};

  function automatic pix_t sat_to_pix(input logic signed [SUM_W-1:0] v);
    pix_t r;
    if (v > SAT_HI) begin
      r = SAT_HI[DW-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[DW-1:0];
    end else begin
      r = v[DW-1:0];
    end
    return r;
  endfunction

endpackage

[design/film_pixel_resolve.sv]
// Each lane pipelines its 32-stage restoring divider; the merge register drives out_valid.
// Throughput: one pixel per cycle whenever no finished result is held at the output.
// A held result stalls the whole pipeline; in_ready drops only while out_valid waits on out_ready.
// Reset (rst_n low, synchronous): pipeline empties, both scales return to 1.0.
// Depends on fpr_pkg, fpr_lane and fpr_merge.
module film_pixel_resolve (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [fpr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  fpr_pkg::scale_t                cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  fpr_pkg::pix_t                  in_red_sum,
  input  fpr_pkg::pix_t                  in_green_sum,
  input  fpr_pkg::pix_t                  in_blue_sum,
  input  fpr_pkg::pix_t                  in_weight_sum,
  input  fpr_pkg::pix_t                  in_splat_red,
  input  fpr_pkg::pix_t                  in_splat_green,
  input  fpr_pkg::pix_t                  in_splat_blue,
  input  logic                           in_last_pixel,
  output logic                           out_valid,
  input  logic                           out_ready,
  output fpr_pkg::pix_t                  out_red,
  output fpr_pkg::pix_t                  out_green,
  output fpr_pkg::pix_t                  out_blue,
  output logic                           out_last
);

  localparam int LS = fpr_pkg::LANE_STAGES;

  fpr_pkg::scale_t splat_scale_r, output_scale_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      splat_scale_r  <= fpr_pkg::SCALE_ONE;
      output_scale_r <= fpr_pkg::SCALE_ONE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fpr_pkg::REG_SPLAT_SCALE:  splat_scale_r  <= cfg_data;
        fpr_pkg::REG_OUTPUT_SCALE: output_scale_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // advance unless a finished result is held
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  logic [LS-1:0] vld_r, vld_nxt;
  logic [LS-1:0] last_r, last_nxt;

  always_comb begin
    vld_nxt  = {vld_r[LS-2:0], in_valid};
    last_nxt = {last_r[LS-2:0], in_last_pixel};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      last_r <= last_nxt;
    end
  end

  fpr_pkg::pix_t  lane_sum   [fpr_pkg::N_LANES];
  fpr_pkg::pix_t  lane_splat [fpr_pkg::N_LANES];
  fpr_pkg::prod_t lane_prod  [fpr_pkg::N_LANES];

  assign lane_sum[0]   = in_red_sum;
  assign lane_sum[1]   = in_green_sum;
  assign lane_sum[2]   = in_blue_sum;
  assign lane_splat[0] = in_splat_red;
  assign lane_splat[1] = in_splat_green;
  assign lane_splat[2] = in_splat_blue;

  for (genvar i = 0; i < fpr_pkg::N_LANES; i++) begin : g_lane
    fpr_lane u_lane (
      .clk          (clk),
      .adv          (adv),
      .sum          (lane_sum[i]),
      .weight       (in_weight_sum),
      .splat        (lane_splat[i]),
      .splat_scale  (splat_scale_r),
      .output_scale (output_scale_r),
      .prod         (lane_prod[i])
    );
  end

  fpr_pkg::fpr_ctl_t merge_ctl;

  always_comb begin
    merge_ctl.adv  = adv;
    merge_ctl.vld  = vld_r[LS-1];
    merge_ctl.last = last_r[LS-1];
  end

  fpr_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (merge_ctl),
    .prod      (lane_prod),
    .out_valid (out_valid),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .out_last  (out_last)
  );

`ifndef SYNTH
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> vld_r[0])
    else $error("accepted request did not enter the pipeline");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("pipeline moved during a stall");

  a_out_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(vld_r[LS-1]))
    else $error("result appeared without a request in the last stage");

  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    adv && vld_r[0] |=> vld_r[1])
    else $error("request lost between pipeline stages");
`endif

endmodule

[design/fpr_lane.sv]
// One color lane: restoring divider pipeline (one quotient bit per stage), splat add, output scale.
// Depends on fpr_pkg; instantiated three times by film_pixel_resolve.
module fpr_lane (
  input  logic           clk,
  input  logic           adv,
  input  fpr_pkg::pix_t   sum,
  input  fpr_pkg::pix_t   weight,
  input  fpr_pkg::pix_t   splat,
  input  fpr_pkg::scale_t splat_scale,
  input  fpr_pkg::scale_t output_scale,
  output fpr_pkg::prod_t  prod
);

  localparam int QW    = fpr_pkg::QW;
  localparam int NUM_W = fpr_pkg::NUM_W;
  localparam int CMP_W = fpr_pkg::CMP_W;
  localparam int DW    = fpr_pkg::DW;
  localparam int F     = fpr_pkg::FRAC_BITS;

  // divider pipeline, stage 0 is the entry register
  logic [NUM_W-1:0]   rem_r [0:QW];
  logic [QW-1:0]      quo_r [0:QW];
  logic [DW-1:0]      dvs_r [0:QW];
  logic               neg_r [0:QW];
  logic               wz_r  [0:QW];
  fpr_pkg::pix_t      raw_r [0:QW];
  fpr_pkg::pix_t      spl_r [0:QW];

  logic signed [NUM_W-1:0] num_s;
  logic [NUM_W-1:0]        abs_num;
  logic [DW-1:0]           abs_w;

  always_comb begin
    num_s   = {sum, {F{1'b0}}};
    abs_num = sum[DW-1] ? NUM_W'(-num_s) : NUM_W'(num_s);
    abs_w   = weight[DW-1] ? DW'(-weight) : DW'(weight);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0] <= abs_num;
      quo_r[0] <= '0;
      dvs_r[0] <= abs_w;
      neg_r[0] <= sum[DW-1] ^ weight[DW-1];
      wz_r[0]  <= (weight == '0);
      raw_r[0] <= sum;
      spl_r[0] <= splat;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_step
    localparam int BIT = QW - k;
    logic [CMP_W-1:0] trial;
    logic [CMP_W-1:0] rem_ext;
    logic             ge;
    logic [NUM_W-1:0] rem_nxt;
    logic [QW-1:0]    quo_nxt;

    always_comb begin
      trial   = CMP_W'(dvs_r[k-1]) << BIT;
      rem_ext = CMP_W'(rem_r[k-1]);
      ge      = (rem_ext >= trial);
      rem_nxt = ge ? NUM_W'(rem_ext - trial) : rem_r[k-1];
      quo_nxt = quo_r[k-1];
      quo_nxt[BIT] = ge;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k] <= rem_nxt;
        quo_r[k] <= quo_nxt;
        dvs_r[k] <= dvs_r[k-1];
        neg_r[k] <= neg_r[k-1];
        wz_r[k]  <= wz_r[k-1];
        raw_r[k] <= raw_r[k-1];
        spl_r[k] <= spl_r[k-1];
      end
    end
  end

  // quotient select, clamp and splat product
  fpr_pkg::pix_t  base_nxt, base_r;
  fpr_pkg::prod_t sprod_nxt, sprod_r;
  logic signed [fpr_pkg::SCW:0] sscale_s, oscale_s;

  always_comb begin
    sscale_s = $signed({1'b0, splat_scale});
    oscale_s = $signed({1'b0, output_scale});
    if (wz_r[QW]) begin
      base_nxt = raw_r[QW];
    end else if (neg_r[QW]) begin
      base_nxt = '0;
    end else if (quo_r[QW][QW-1]) begin
      base_nxt = fpr_pkg::SAT_HI[DW-1:0];
    end else begin
      base_nxt = quo_r[QW];
    end
    sprod_nxt = fpr_pkg::prod_t'(spl_r[QW]) * fpr_pkg::prod_t'(sscale_s);
  end

  // splat add with saturation, output scale product
  logic signed [fpr_pkg::SUM_W-1:0] mid_sum;
  fpr_pkg::pix_t  mid_r;
  fpr_pkg::prod_t oprod_nxt, oprod_r;

  always_comb begin
    mid_sum   = fpr_pkg::SUM_W'(base_r) + fpr_pkg::SUM_W'(sprod_r >>> F);
    oprod_nxt = fpr_pkg::prod_t'(mid_r) * fpr_pkg::prod_t'(oscale_s);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      base_r  <= base_nxt;
      sprod_r <= sprod_nxt;
      mid_r   <= fpr_pkg::sat_to_pix(mid_sum);
      oprod_r <= oprod_nxt;
    end
  end

  assign prod = oprod_r;

endmodule

[design/fpr_merge.sv]
// Merge stage: final shift and saturation of the three lanes into the output register.
// Depends on fpr_pkg; driven by fpr_lane results and the valid/last pipe of the top level.
module fpr_merge (
  input  logic              clk,
  input  logic              rst_n,
  input  fpr_pkg::fpr_ctl_t ctl,
  input  fpr_pkg::prod_t    prod [fpr_pkg::N_LANES],
  output logic              out_valid,
  output fpr_pkg::pix_t     out_red,
  output fpr_pkg::pix_t     out_green,
  output fpr_pkg::pix_t     out_blue,
  output logic              out_last
);

  logic          valid_r;
  logic          last_r;
  fpr_pkg::pix_t res_r [fpr_pkg::N_LANES];
  fpr_pkg::pix_t res_nxt [fpr_pkg::N_LANES];

  always_comb begin
    for (int i = 0; i < fpr_pkg::N_LANES; i++) begin
      res_nxt[i] = fpr_pkg::sat_to_pix(
                     fpr_pkg::SUM_W'(prod[i] >>> fpr_pkg::FRAC_BITS));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.adv) begin
      valid_r <= ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      last_r <= ctl.last;
      for (int i = 0; i < fpr_pkg::N_LANES; i++) begin
        res_r[i] <= res_nxt[i];
      end
    end
  end

  assign out_valid = valid_r;
  assign out_last  = last_r;
  assign out_red   = res_r[0];
  assign out_green = res_r[1];
  assign out_blue  = res_r[2];

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// Self-checking bench for film_pixel_resolve: directed and random pixels across scale settings,
// with bursty input, varied output backpressure and a long output hold-off.
// Depends on fpr_pkg and the film_pixel_resolve RTL; reads no files.
module testbench;

  localparam int HOLD_TRIGGER   = 200;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_PIXELS   = 80;
  localparam int N_PHASES       = 6;
  localparam int TAIL_CYCLES    = 60;
  localparam int MAX_REPORTS    = 40;

  localparam longint PIX_MAX = 64'sd2147483647;
  localparam longint PIX_MIN = -PIX_MAX - 1;

  localparam fpr_pkg::pix_t P_MAX = 32'sh7FFFFFFF;
  localparam fpr_pkg::pix_t P_MIN = 32'sh80000000;
  localparam fpr_pkg::pix_t P_ONE = 32'sh00010000;

  typedef enum logic [1:0] {RDY_ALWAYS, RDY_RANDOM, RDY_PATTERN, RDY_SPARSE} rdy_mode_t;
  typedef enum logic {SEND_STREAM, SEND_BURST} send_mode_t;

  typedef struct {
    fpr_pkg::pix_t red, green, blue, weight, splat_r, splat_g, splat_b;
    logic last;
  } pixel_req_t;

  typedef struct {
    fpr_pkg::pix_t red, green, blue;
    logic last;
  } pixel_res_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [fpr_pkg::CFG_IDX_W-1:0] cfg_index = fpr_pkg::REG_SPLAT_SCALE;
  fpr_pkg::scale_t               cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  fpr_pkg::pix_t                 in_red_sum = '0;
  fpr_pkg::pix_t                 in_green_sum = '0;
  fpr_pkg::pix_t                 in_blue_sum = '0;
  fpr_pkg::pix_t                 in_weight_sum = '0;
  fpr_pkg::pix_t                 in_splat_red = '0;
  fpr_pkg::pix_t                 in_splat_green = '0;
  fpr_pkg::pix_t                 in_splat_blue = '0;
  logic                          in_last_pixel = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  fpr_pkg::pix_t                 out_red, out_green, out_blue;
  logic                          out_last;

  film_pixel_resolve uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_red_sum(in_red_sum), .in_green_sum(in_green_sum), .in_blue_sum(in_blue_sum),
    .in_weight_sum(in_weight_sum), .in_splat_red(in_splat_red),
    .in_splat_green(in_splat_green), .in_splat_blue(in_splat_blue),
    .in_last_pixel(in_last_pixel),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue), .out_last(out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pixel_req_t      pixel_q[$];
  pixel_res_t      resolved_q[$];
  fpr_pkg::scale_t splat_scale_m = fpr_pkg::SCALE_ONE;
  fpr_pkg::scale_t out_scale_m = fpr_pkg::SCALE_ONE;
  send_mode_t      send_mode = SEND_STREAM;
  rdy_mode_t       rdy_mode = RDY_ALWAYS;
  bit              in_fire, out_fire, cfg_fire;
  int              pixels_in, pixels_out, zero_weight_cnt, neg_weight_cnt, settings_cnt;
  int              mismatches, idle_cycles;
  int              burst_left, gap_left;
  int              hold_left, rdy_tick;
  bit              hold_done;

  function automatic longint clip32(longint v);
    if (v > PIX_MAX) return PIX_MAX;
    if (v < PIX_MIN) return PIX_MIN;
    return v;
  endfunction

  function automatic fpr_pkg::pix_t resolve_chan(fpr_pkg::pix_t sum, fpr_pkg::pix_t weight,
                                                 fpr_pkg::pix_t splat,
                                                 fpr_pkg::scale_t s_scale,
                                                 fpr_pkg::scale_t o_scale);
    longint base, mid, res, ss, os;
    ss = s_scale;
    os = o_scale;
    base = sum;
    // normalize, truncating toward zero, then clamp below at zero
    if (weight != 0) begin
      base = clip32((longint'(sum) <<< fpr_pkg::FRAC_BITS) / longint'(weight));
      if (base < 0) base = 0;
    end
    mid = clip32(base + ((longint'(splat) * ss) >>> fpr_pkg::FRAC_BITS));
    res = clip32((mid * os) >>> fpr_pkg::FRAC_BITS);
    return res[fpr_pkg::DW-1:0];
  endfunction

  function automatic pixel_res_t resolve_pixel(pixel_req_t p);
    pixel_res_t r;
    r.red   = resolve_chan(p.red, p.weight, p.splat_r, splat_scale_m, out_scale_m);
    r.green = resolve_chan(p.green, p.weight, p.splat_g, splat_scale_m, out_scale_m);
    r.blue  = resolve_chan(p.blue, p.weight, p.splat_b, splat_scale_m, out_scale_m);
    r.last  = p.last;
    return r;
  endfunction

  function automatic fpr_pkg::pix_t rand_level();
    case ($urandom_range(0, 6))
      0, 1: return fpr_pkg::pix_t'($urandom);
      2: return fpr_pkg::pix_t'($urandom_range(0, 32'hFFFFF));
      3: return -fpr_pkg::pix_t'($urandom_range(0, 32'hFFFFF));
      4: return $urandom_range(0, 1) ? P_MAX : P_MIN;
      5: return fpr_pkg::pix_t'($urandom_range(0, 32'hFFFFFF));
      default: return fpr_pkg::pix_t'($urandom_range(0, 3)) - 1;
    endcase
  endfunction

  function automatic fpr_pkg::pix_t rand_weight();
    case ($urandom_range(0, 6))
      0: return '0;
      1, 2: return fpr_pkg::pix_t'($urandom_range(32'h100, 32'h80000));
      3: return $urandom_range(0, 1) ? fpr_pkg::pix_t'($urandom_range(1, 255))
                                     : -fpr_pkg::pix_t'($urandom_range(1, 255));
      4: return -fpr_pkg::pix_t'($urandom_range(1, 32'h80000));
      default: return fpr_pkg::pix_t'($urandom);
    endcase
  endfunction

  function automatic fpr_pkg::pix_t rand_splat();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return fpr_pkg::pix_t'($urandom_range(0, 32'h3FFFF)) - fpr_pkg::pix_t'(32'h20000);
      2: return $urandom_range(0, 1) ? P_MAX : P_MIN;
      default: return fpr_pkg::pix_t'($urandom);
    endcase
  endfunction

  task automatic push_pixel(fpr_pkg::pix_t r, fpr_pkg::pix_t g, fpr_pkg::pix_t b,
                            fpr_pkg::pix_t w, fpr_pkg::pix_t sr, fpr_pkg::pix_t sg,
                            fpr_pkg::pix_t sb, logic last);
    pixel_req_t p;
    p.red = r; p.green = g; p.blue = b; p.weight = w;
    p.splat_r = sr; p.splat_g = sg; p.splat_b = sb; p.last = last;
    pixel_q.push_back(p);
  endtask

  task automatic push_random_pixel();
    push_pixel(rand_level(), rand_level(), rand_level(), rand_weight(),
               rand_splat(), rand_splat(), rand_splat(), $urandom_range(0, 7) == 0);
  endtask

  task automatic write_scale(logic [fpr_pkg::CFG_IDX_W-1:0] idx, fpr_pkg::scale_t value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(negedge clk); while (!cfg_fire);
    cfg_valid <= 1'b0;
  endtask

  // hold until nothing is queued, offered or outstanding
  task automatic wait_drain();
    do @(posedge clk); while (pixel_q.size() != 0 || in_valid || resolved_q.size() != 0);
  endtask

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) $error("%s: expected %0d, actual %0d", name, want, got);
    end
  endtask

  always @(negedge clk) begin : drive_pixels
    pixel_req_t p;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (send_mode == SEND_BURST && gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pixel_q.size() > 0) begin
        p = pixel_q.pop_front();
        in_red_sum     <= p.red;
        in_green_sum   <= p.green;
        in_blue_sum    <= p.blue;
        in_weight_sum  <= p.weight;
        in_splat_red   <= p.splat_r;
        in_splat_green <= p.splat_g;
        in_splat_blue  <= p.splat_b;
        in_last_pixel  <= p.last;
        in_valid       <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 24);
          gap_left   = $urandom_range(1, 8);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : drive_ready
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!hold_done && pixels_in >= HOLD_TRIGGER) begin
      // long hold-off: let the pipeline fill and back up into the input
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else begin
      rdy_tick++;
      case (rdy_mode)
        RDY_ALWAYS:  out_ready <= 1'b1;
        RDY_RANDOM:  out_ready <= $urandom_range(0, 3) != 0;
        RDY_PATTERN: out_ready <= (rdy_tick % 7) < 4;
        RDY_SPARSE:  out_ready <= $urandom_range(0, 3) == 0;
        default:     out_ready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin : watch_ports
    pixel_req_t p;
    pixel_res_t want;
    in_fire  = rst_n && in_valid && in_ready;
    out_fire = rst_n && out_valid && out_ready;
    cfg_fire = rst_n && cfg_valid && cfg_ready;
    if (!rst_n) begin
      splat_scale_m = fpr_pkg::SCALE_ONE;
      out_scale_m   = fpr_pkg::SCALE_ONE;
      idle_cycles   = 0;
    end else begin
      if (cfg_fire) begin
        case (cfg_index)
          fpr_pkg::REG_SPLAT_SCALE:  splat_scale_m = cfg_data;
          fpr_pkg::REG_OUTPUT_SCALE: out_scale_m = cfg_data;
          default: ;
        endcase
      end
      if (in_fire) begin
        p.red = in_red_sum; p.green = in_green_sum; p.blue = in_blue_sum;
        p.weight = in_weight_sum; p.splat_r = in_splat_red;
        p.splat_g = in_splat_green; p.splat_b = in_splat_blue; p.last = in_last_pixel;
        resolved_q.push_back(resolve_pixel(p));
        pixels_in++;
        if (p.weight == 0) zero_weight_cnt++;
        else if (p.weight < 0) neg_weight_cnt++;
      end
      if (out_fire) begin
        if (resolved_q.size() == 0) begin
          mismatches++;
          $error("result accepted with no pixel pending");
        end else begin
          want = resolved_q.pop_front();
          check_field("out_red", want.red, out_red);
          check_field("out_green", want.green, out_green);
          check_field("out_blue", want.blue, out_blue);
          check_field("out_last", want.last, out_last);
          pixels_out++;
        end
      end
      if (in_fire || out_fire || cfg_fire) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                 idle_cycles, resolved_q.size());
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin : run_test
    fpr_pkg::scale_t s_set, o_set;
    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed pixels at the reset scales of 1.0
    push_pixel(0, 0, 0, 0, 0, 0, 0, 1'b0);
    push_pixel(P_MAX, P_MIN, -1, 0, 0, 0, 0, 1'b1);           // raw pass-through
    push_pixel(3 * P_ONE, -P_ONE, P_MAX, P_ONE, 0, 0, 0, 1'b0);
    push_pixel(2 * P_ONE, -2 * P_ONE, 0, -P_ONE, 0, 0, 0, 1'b0); // negative weight
    push_pixel(P_ONE, -1, P_MAX, 1, 0, 0, 0, 1'b0);           // quotient overflow
    push_pixel(P_MIN, P_MAX, 1, -1, 0, 0, 0, 1'b1);
    push_pixel(P_MIN, P_MAX, -P_ONE, P_MIN, 0, 0, 0, 1'b0);
    push_pixel(P_MAX, P_MIN, P_ONE, P_MAX, 0, 0, 0, 1'b0);
    push_pixel(P_MAX, P_MIN, 0, 0, P_MAX, P_MIN, -1, 1'b0);   // splat add overflow
    push_pixel(7, -7, 7, 3 * P_ONE, 0, 0, 0, 1'b0);           // truncation toward zero
    push_pixel(-7, 7, 5, -3 * P_ONE, P_ONE, -P_ONE, 1, 1'b1);
    push_pixel(0, 0, 0, P_ONE, P_MIN, P_MAX, -P_ONE, 1'b0);
    push_pixel(P_MAX, P_MAX, P_MAX, 0, P_MAX, P_MAX, P_MAX, 1'b1);
    push_pixel(P_MIN, P_MIN, P_MIN, 0, P_MIN, P_MIN, P_MIN, 1'b0);
    push_pixel(1, 2, 3, 32'sh00008000, -1, -2, -3, 1'b0);
    push_pixel(32'sh55555555, 32'shAAAAAAAA, 32'sh0F0F0F0F, 32'shAAAAAAAA,
               32'sh55555555, 32'shAAAAAAAA, 32'shF0F0F0F0, 1'b1);
    push_pixel(32'shAAAAAAAA, 32'sh55555555, 32'shF0F0F0F0, 32'sh55555555,
               32'shAAAAAAAA, 32'sh55555555, 32'sh0F0F0F0F, 1'b0);
    repeat (3) push_random_pixel();
    settings_cnt = 1;
    wait_drain();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin s_set = '0; o_set = '1; send_mode = SEND_BURST; rdy_mode = RDY_RANDOM; end
        1: begin s_set = '1; o_set = '0; send_mode = SEND_STREAM; rdy_mode = RDY_ALWAYS; end
        2: begin
          s_set = fpr_pkg::SCALE_ONE; o_set = fpr_pkg::SCALE_ONE;
          send_mode = SEND_STREAM; rdy_mode = RDY_PATTERN;
        end
        3: begin
          s_set = fpr_pkg::scale_t'($urandom_range(0, 24'hFFFFFF));
          o_set = fpr_pkg::scale_t'($urandom_range(0, 24'hFFFFFF));
          send_mode = SEND_BURST; rdy_mode = RDY_SPARSE;
        end
        4: begin s_set = '1; o_set = '1; send_mode = SEND_BURST; rdy_mode = RDY_RANDOM; end
        default: begin
          s_set = fpr_pkg::scale_t'($urandom_range(0, 2 * fpr_pkg::SCALE_ONE));
          o_set = fpr_pkg::scale_t'($urandom_range(1, 2 * fpr_pkg::SCALE_ONE));
          send_mode = SEND_STREAM; rdy_mode = RDY_RANDOM;
        end
      endcase
      write_scale(fpr_pkg::REG_SPLAT_SCALE, s_set);
      write_scale(fpr_pkg::REG_OUTPUT_SCALE, o_set);
      settings_cnt++;
      repeat (PHASE_PIXELS) push_random_pixel();
      // pause the sender until every result of this setting is back
      wait_drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Resolved %0d of %0d pixels over %0d scale settings (%0d zero, %0d negative weight).",
             pixels_out, pixels_in, settings_cnt, zero_weight_cnt, neg_weight_cnt);
    $display("Field mismatches and unexpected results: %0d", mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[filelist.f]
design/fpr_pkg.sv
design/fpr_lane.sv
design/fpr_merge.sv
design/film_pixel_resolve.sv
tb/testbench.sv
